### hw/rtl/gmt_pkg.sv
// ----------------------------------------------------------------------------
// gmt_pkg: shared types and constants for the grid map trilinear lookup
// Word formats, register indexes, opcodes and pipeline control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gmt_pkg;

    // default sizes
    localparam int GRID_DIM_DEF   = 32;
    localparam int NUM_MAPS_DEF   = 4;
    localparam int VALUE_BITS_DEF = 32;

    localparam int FRAC_BITS = 10;

    // opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register indexes
    localparam logic [2:0] CFG_CORNER_X    = 3'd0;
    localparam logic [2:0] CFG_CORNER_Y    = 3'd1;
    localparam logic [2:0] CFG_CORNER_Z    = 3'd2;
    localparam logic [2:0] CFG_INV_SPACING = 3'd3;
    localparam logic [2:0] CFG_POINTS_X    = 3'd4;
    localparam logic [2:0] CFG_POINTS_Y    = 3'd5;
    localparam logic [2:0] CFG_POINTS_Z    = 3'd6;

    // 100.0 in Q16.16
    localparam logic signed [31:0] OUTSIDE_ENERGY = 32'sd6553600;

    typedef struct packed {
        logic               op;
        logic [1:0]         map_sel;
        logic [4:0]         point_x;
        logic [4:0]         point_y;
        logic [4:0]         point_z;
        logic signed [31:0] point_value;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
    } gmt_in_t;

    typedef struct packed {
        logic signed [31:0] energy;
        logic               outside;
    } gmt_out_t;

    // grid coordinate of one axis
    typedef struct packed {
        logic                 in_grid;
        logic [5:0]           idx;
        logic [FRAC_BITS-1:0] frac;
    } gmt_axis_t;

    // control traveling with the corner values into the blend stages
    typedef struct packed {
        logic                 valid;
        logic                 bad_map;
        logic                 outside;
        logic [2:0]           par;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [FRAC_BITS-1:0] fz;
    } gmt_blend_t;

endpackage

`default_nettype wire

### hw/rtl/grid_map_trilinear_lookup.sv
// ----------------------------------------------------------------------------
// grid_map_trilinear_lookup: trilinear lookup in stored 3D energy maps
// Stores NUM_MAPS grids of energy values and blends eight neighbors per query.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word on item is taken at each clock edge with start
//   high and busy low. busy is always low, so one word per cycle is taken.
//   op = write stores point_value at (point_x, point_y, point_z) of map
//   map_sel and gives no result. op = query gives one result word.
//   Result channel: done is high for one cycle with energy and outside on
//   result; the receiver cannot stall, so nothing waits.
//   Pipeline: a query word passes 3 coordinate stages, 1 RAM read and
//   3 blend stages before its result appears. Throughput is one
//   word per cycle, fixed by the eight RAM banks split on index parity,
//   each read once per query.
//   Writes pass through the same stages and update the RAM at the read
//   stage, so later queries always see earlier writes.
//   Config: cfg_we/cfg_addr/cfg_wdata write one register per cycle; write
//   only while no query is in flight.
//   Reset: clears the pipeline valid bits and loads the register defaults.
//   Map contents are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_map_trilinear_lookup
    import gmt_pkg::*;
#(
    parameter int GRID_DIM   = GRID_DIM_DEF,
    parameter int NUM_MAPS   = NUM_MAPS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire gmt_in_t     item,
    output logic             done,
    output gmt_out_t         result,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata
);

    localparam int VB      = VALUE_BITS;
    localparam int HALF    = (GRID_DIM + 1) / 2;
    localparam int HB      = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int MAP_W   = (NUM_MAPS > 1) ? $clog2(NUM_MAPS) : 1;
    localparam int BANK_DP = NUM_MAPS << (3 * HB);
    localparam int AW      = $clog2(BANK_DP);

    // configuration registers
    logic signed [23:0] corner_x_reg, corner_y_reg, corner_z_reg;
    logic [15:0]        inv_spacing_reg;
    logic [5:0]         points_x_reg, points_y_reg, points_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_x_reg    <= '0;
            corner_y_reg    <= '0;
            corner_z_reg    <= '0;
            inv_spacing_reg <= 16'd4096;
            points_x_reg    <= 6'd32;
            points_y_reg    <= 6'd32;
            points_z_reg    <= 6'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_CORNER_X:    corner_x_reg    <= cfg_wdata;
                CFG_CORNER_Y:    corner_y_reg    <= cfg_wdata;
                CFG_CORNER_Z:    corner_z_reg    <= cfg_wdata;
                CFG_INV_SPACING: inv_spacing_reg <= cfg_wdata[15:0];
                CFG_POINTS_X:    points_x_reg    <= cfg_wdata[5:0];
                CFG_POINTS_Y:    points_y_reg    <= cfg_wdata[5:0];
                CFG_POINTS_Z:    points_z_reg    <= cfg_wdata[5:0];
                default:         ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // write value saturated to the stored width
    logic signed [VB-1:0] wval;
    generate
        if (VB < 32)
        begin : g_wsat
            localparam logic signed [31:0] HI = 32'((64'sd1 <<< (VB - 1)) - 64'sd1);
            localparam logic signed [31:0] LO = -HI - 32'sd1;
            logic signed [31:0] wclip;
            assign wclip = (item.point_value > HI) ? HI :
                           (item.point_value < LO) ? LO : item.point_value;
            assign wval  = wclip[VB-1:0];
        end
        else
        begin : g_wext
            assign wval = VB'(item.point_value);
        end
    endgenerate

    // item stages 1..3 alongside the coordinate units
    logic                 v1_reg, v2_reg, v3_reg;
    logic                 op1_reg, op2_reg, op3_reg;
    logic [1:0]           map1_reg, map2_reg, map3_reg;
    logic [4:0]           px1_reg, px2_reg, px3_reg;
    logic [4:0]           py1_reg, py2_reg, py3_reg;
    logic [4:0]           pz1_reg, pz2_reg, pz3_reg;
    logic signed [VB-1:0] val1_reg, val2_reg, val3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op1_reg  <= item.op;
        map1_reg <= item.map_sel;
        px1_reg  <= item.point_x;
        py1_reg  <= item.point_y;
        pz1_reg  <= item.point_z;
        val1_reg <= wval;
        op2_reg  <= op1_reg;
        map2_reg <= map1_reg;
        px2_reg  <= px1_reg;
        py2_reg  <= py1_reg;
        pz2_reg  <= pz1_reg;
        val2_reg <= val1_reg;
        op3_reg  <= op2_reg;
        map3_reg <= map2_reg;
        px3_reg  <= px2_reg;
        py3_reg  <= py2_reg;
        pz3_reg  <= pz2_reg;
        val3_reg <= val2_reg;
    end

    // grid coordinates
    gmt_axis_t ax, ay, az;

    gmt_axis #(.GRID_DIM(GRID_DIM)) u_axis_x (
        .clk(clk), .pos(item.pos_x), .corner(corner_x_reg),
        .inv_spacing(inv_spacing_reg), .points(points_x_reg), .axis(ax)
    );
    gmt_axis #(.GRID_DIM(GRID_DIM)) u_axis_y (
        .clk(clk), .pos(item.pos_y), .corner(corner_y_reg),
        .inv_spacing(inv_spacing_reg), .points(points_y_reg), .axis(ay)
    );
    gmt_axis #(.GRID_DIM(GRID_DIM)) u_axis_z (
        .clk(clk), .pos(item.pos_z), .corner(corner_z_reg),
        .inv_spacing(inv_spacing_reg), .points(points_z_reg), .axis(az)
    );

    // stage 3: RAM access, one bank per index parity
    logic             map_ok, wr_ok;
    logic [2:0]       wr_bank;
    logic [MAP_W-1:0] m_addr;
    logic [AW-1:0]    waddr;
    logic [7:0]       wx8, wy8, wz8;
    logic [VB-1:0]    rdata [8];

    always_comb
    begin
        map_ok  = (32'(map3_reg) < NUM_MAPS);
        wr_ok   = v3_reg && (op3_reg == OP_WRITE) && map_ok &&
                  (32'(px3_reg) < GRID_DIM) && (32'(py3_reg) < GRID_DIM) &&
                  (32'(pz3_reg) < GRID_DIM);
        wr_bank = {pz3_reg[0], py3_reg[0], px3_reg[0]};
        m_addr  = MAP_W'({6'b0, map3_reg});
        wx8     = 8'(px3_reg);
        wy8     = 8'(py3_reg);
        wz8     = 8'(pz3_reg);
        waddr   = AW'({m_addr, wz8[HB:1], wy8[HB:1], wx8[HB:1]});
    end

    genvar b;
    generate
        for (b = 0; b < 8; b++)
        begin : g_bank
            localparam logic [2:0] BP = 3'(b);
            logic [7:0]    hx8, hy8, hz8;
            logic [AW-1:0] raddr;

            // half index: the even bank takes idx+1 when idx is odd
            assign hx8 = 8'(ax.idx) + 8'(ax.idx[0] & ~BP[0]);
            assign hy8 = 8'(ay.idx) + 8'(ay.idx[0] & ~BP[1]);
            assign hz8 = 8'(az.idx) + 8'(az.idx[0] & ~BP[2]);
            assign raddr = AW'({m_addr, hz8[HB:1], hy8[HB:1], hx8[HB:1]});

            gmt_ram #(.WIDTH(VB), .DEPTH(BANK_DP)) u_ram (
                .clk(clk),
                .we(wr_ok && (wr_bank == BP)),
                .waddr(waddr),
                .wdata(val3_reg),
                .raddr(raddr),
                .rdata(rdata[b])
            );
        end
    endgenerate

    // stage 4: control that goes with the read data
    gmt_blend_t ctl_reg, ctl_next;

    always_comb
    begin
        ctl_next.valid   = v3_reg && (op3_reg == OP_QUERY);
        ctl_next.bad_map = !map_ok;
        ctl_next.outside = !(ax.in_grid && ay.in_grid && az.in_grid);
        ctl_next.par     = {az.idx[0], ay.idx[0], ax.idx[0]};
        ctl_next.fx      = ax.frac;
        ctl_next.fy      = ay.frac;
        ctl_next.fz      = az.frac;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    logic signed [VB-1:0] cval [8];
    always_comb
    begin
        for (int n = 0; n < 8; n++)
        begin
            cval[n] = $signed(rdata[n]);
        end
    end

    gmt_interp #(.VALUE_BITS(VB)) u_interp (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(ctl_reg),
        .cval(cval),
        .done(done),
        .result(result)
    );

    // checks
    a_done_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && item.op == OP_QUERY, 7))
        else $error("result word without a matching query");

    a_query_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == OP_QUERY) |-> ##7 done)
        else $error("query lost in pipeline");

    a_outside_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.outside) |-> (result.energy == OUTSIDE_ENERGY))
        else $error("outside result with wrong energy");

endmodule

`default_nettype wire

### hw/rtl/gmt_ram.sv
// ----------------------------------------------------------------------------
// gmt_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/gmt_axis.sv
// ----------------------------------------------------------------------------
// gmt_axis: grid coordinate of one axis
// Three stages: offset from corner, scale by inverse spacing, range check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmt_axis
    import gmt_pkg::*;
#(
    parameter int GRID_DIM = GRID_DIM_DEF
) (
    input  wire logic               clk,
    input  wire logic signed [23:0] pos,
    input  wire logic signed [23:0] corner,
    input  wire logic        [15:0] inv_spacing,
    input  wire logic        [5:0]  points,
    output gmt_axis_t               axis
);

    logic signed [24:0] d_reg;
    logic signed [40:0] prod_reg;
    gmt_axis_t          axis_reg;
    gmt_axis_t          axis_next;

    logic [8:0]  n_pts;
    logic [18:0] lim;
    logic [27:0] g;

    // stage 1: offset
    always_ff @(posedge clk)
    begin
        d_reg <= $signed({pos[23], pos}) - $signed({corner[23], corner});
    end

    // stage 2: scale
    always_ff @(posedge clk)
    begin
        prod_reg <= d_reg * $signed({1'b0, inv_spacing});
    end

    // stage 3: clamp point count, split integer and fraction, range check
    always_comb
    begin
        n_pts = (9'(points) > 9'(GRID_DIM)) ? 9'(GRID_DIM) : 9'(points);
        lim   = {n_pts - 9'd1, 10'b0};
        g     = prod_reg[39:12];
        axis_next.in_grid = !prod_reg[40] && (n_pts >= 9'd2) && (g < 28'(lim));
        axis_next.idx     = g[15:10];
        axis_next.frac    = g[FRAC_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        axis_reg <= axis_next;
    end

    assign axis = axis_reg;

endmodule

`default_nettype wire

### hw/rtl/gmt_interp.sv
// ----------------------------------------------------------------------------
// gmt_interp: trilinear blend of eight corner values
// Three stages: four lerps along x, two along y, one along z plus result mux.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmt_interp
    import gmt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire gmt_blend_t                   ctl,
    input  wire logic signed [VALUE_BITS-1:0] cval [8],
    output logic                              done,
    output gmt_out_t                          result
);

    localparam int VB = VALUE_BITS;
    localparam logic signed [VB+11:0] RND = (VB+12)'(512);

    // a + round((b - a) * f / 1024), ties rounded up, as a*(1-f) + b*f
    function automatic logic signed [VB-1:0] lerp(
        input logic signed [VB-1:0]  a,
        input logic signed [VB-1:0]  b,
        input logic [FRAC_BITS-1:0]  f
    );
        logic signed [VB:0]    diff;
        logic signed [VB+11:0] prod;
        logic signed [VB+11:0] sum;
        logic signed [VB+11:0] t;
        diff = $signed({b[VB-1], b}) - $signed({a[VB-1], a});
        prod = diff * $signed({1'b0, f});
        sum  = prod + RND;
        t    = sum >>> FRAC_BITS;
        return a + t[VB-1:0];
    endfunction

    gmt_blend_t           ctl_e_reg, ctl_f_reg;
    logic signed [VB-1:0] cx_reg [4];
    logic signed [VB-1:0] cy_reg [2];
    logic signed [VB-1:0] nb     [8];
    logic signed [VB-1:0] e_full;
    logic signed [31:0]   e_sat;
    gmt_out_t             result_next;
    logic                 done_reg;
    gmt_out_t             result_reg;

    // undo the bank parity swap: neighbor {k,j,i} sits in bank {k,j,i} ^ par
    always_comb
    begin
        for (int n = 0; n < 8; n++)
        begin
            nb[n] = cval[3'(n) ^ ctl.par];
        end
    end

    // stage E: along x
    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 4; n++)
        begin
            cx_reg[n] <= lerp(nb[2*n], nb[2*n+1], ctl.fx);
        end
    end

    // stage F: along y
    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 2; n++)
        begin
            cy_reg[n] <= lerp(cx_reg[2*n], cx_reg[2*n+1], ctl_e_reg.fy);
        end
    end

    // stage G: along z, saturate to 32 bits
    assign e_full = lerp(cy_reg[0], cy_reg[1], ctl_f_reg.fz);

    generate
        if (VB > 32)
        begin : g_sat
            localparam logic signed [VB-1:0] HI = VB'(64'sd2147483647);
            localparam logic signed [VB-1:0] LO = VB'(-64'sd2147483648);
            assign e_sat = (e_full > HI) ? 32'sh7fffffff :
                           (e_full < LO) ? 32'sh80000000 : e_full[31:0];
        end
        else
        begin : g_ext
            assign e_sat = 32'(e_full);
        end
    endgenerate

    always_comb
    begin
        if (ctl_f_reg.bad_map)
        begin
            result_next.energy  = '0;
            result_next.outside = 1'b0;
        end
        else if (ctl_f_reg.outside)
        begin
            result_next.energy  = OUTSIDE_ENERGY;
            result_next.outside = 1'b1;
        end
        else
        begin
            result_next.energy  = e_sat;
            result_next.outside = 1'b0;
        end
    end

    // control and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_e_reg <= '0;
            ctl_f_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ctl_e_reg <= ctl;
            ctl_f_reg <= ctl_e_reg;
            done_reg  <= ctl_f_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
